// ----- src/spq_pkg.sv -----
// spq_pkg: shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_dpath and sorted_priority_queue_top; no dependencies.
`timescale 1ns / 1ps

package spq_pkg;

   // Operation codes carried on the request tuser.
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_NOP     = 2'd3
   } spq_op_type;

   // Result status codes carried on the response tuser.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_FULL      = 2'd2
   } spq_status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPARE = 2'd1,
      S_UPDATE  = 2'd2
   } spq_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;     // capture request beat
      logic compare;  // register per-cell compare results
      logic update;   // apply operation, load response register
   } spq_cmd_type;

   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int RDATA_W  = 40;  // value_out, count, is_empty, padded to bytes

endpackage

// ----- src/spq_ctrl.sv -----
// spq_ctrl: operation sequencer and response valid flag.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output spq_pkg::spq_cmd_type cmd
);

   spq_pkg::spq_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = spq_pkg::S_COMPARE;
            end
         end
         spq_pkg::S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = spq_pkg::S_UPDATE;
         end
         spq_pkg::S_UPDATE: begin
            // wait here while a previous response still sits unread
            if (out_free) begin
               cmd.update = 1'b1;
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = spq_pkg::S_COMPARE;
               end else begin
                  state_in = spq_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   a_load_then_compare: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.compare)
      else $error("load not followed by compare");

   a_update_gives_response: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_tvalid)
      else $error("update did not raise response valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten while unread");

endmodule

// ----- src/spq_dpath.sv -----
// spq_dpath: shifting sorted store, entry count, order register, response register.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spq_pkg::spq_cmd_type         cmd,
   input  logic [1:0]                   req_func,
   input  logic [spq_pkg::VALUE_W-1:0]  req_value,
   input  logic                         csr_write,
   input  logic                         csr_order,
   output logic [spq_pkg::VALUE_W-1:0]  rsp_value,
   output spq_pkg::spq_status_type      rsp_status,
   output logic [spq_pkg::COUNT_W-1:0]  rsp_count,
   output logic                         rsp_empty
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (CNT_W > spq_pkg::COUNT_W) ? CNT_W : spq_pkg::COUNT_W;

   spq_pkg::spq_op_type                func_ff;
   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic                               order_ff;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic signed [spq_pkg::VALUE_W-1:0] entry_ff [CAPACITY];
   logic signed [spq_pkg::VALUE_W-1:0] entry_in [CAPACITY];
   logic [CAPACITY-1:0]                beats_ff, beats_in;
   logic [CAPACITY-1:0]                cand, first, at_or_after;
   logic                               full, empty;

   logic [spq_pkg::VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   spq_pkg::spq_status_type            rsp_status_ff, rsp_status_in;
   logic [spq_pkg::COUNT_W-1:0]        rsp_count_ff;
   logic                               rsp_empty_ff;
   logic [EXT_W-1:0]                   count_ext;

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // Per-cell strict compare against the new value, live cells only.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         beats_in[i] = (CNT_W'(i) < count_ff) &&
                       (order_ff ? (value_ff > entry_ff[i]) : (value_ff < entry_ff[i]));
      end
   end

   // Insert point: first beaten cell, else the tail slot.
   assign cand        = beats_ff | (CAPACITY'(1) << count_ff);
   assign first       = cand & (~cand + CAPACITY'(1));
   assign at_or_after = ~(first - CAPACITY'(1));

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entry_in[i] = entry_ff[i];
      end
      count_in      = count_ff;
      rsp_value_in  = '0;
      rsp_status_in = spq_pkg::ST_OK;
      unique case (func_ff)
         spq_pkg::OP_ENQUEUE: begin
            if (full) begin
               rsp_status_in = spq_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (first[i]) begin
                     entry_in[i] = value_ff;
                  end else if (at_or_after[i] && i > 0) begin
                     entry_in[i] = entry_ff[(i > 0) ? i - 1 : 0];
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
            if (empty) begin
               rsp_status_in = spq_pkg::ST_UNDERFLOW;
            end else begin
               rsp_value_in = entry_ff[0];
               if (func_ff == spq_pkg::OP_DEQUEUE) begin
                  for (int i = 0; i < CAPACITY - 1; i++) begin
                     entry_in[i] = entry_ff[i + 1];
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign count_ext = EXT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         order_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            count_ff <= count_in;
         end
         if (csr_write) begin
            order_ff <= csr_order;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= spq_pkg::spq_op_type'(req_func);
         value_ff <= req_value;
      end
      if (cmd.compare) begin
         beats_ff <= beats_in;
      end
      if (cmd.update) begin
         for (int i = 0; i < CAPACITY; i++) begin
            entry_ff[i] <= entry_in[i];
         end
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_ext[spq_pkg::COUNT_W-1:0];
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_empty  = rsp_empty_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_onehot: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && func_ff == spq_pkg::OP_ENQUEUE && !full) |-> $onehot(first))
      else $error("insert point not unique");

endmodule

// ----- src/sorted_priority_queue_top.sv -----
// Sorted priority queue: one op (enqueue/dequeue/peek) per request beat, one response each.
// Response valid is raised after the request beat is taken, through the compare state, then the update state
// (which waits while a response is unread), then the response register; ops do not overlap in compare/update.
// A request is taken in the update cycle of the previous op if the response slot is free.
// Reset (sync, active high): queue empty, order = smallest first; stored words not cleared.
// Depends on spq_pkg, spq_ctrl, spq_dpath.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,

   // Request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [spq_pkg::VALUE_W-1:0]  req_tdata,  // [31:0] value
   input  logic [1:0]                   req_tuser,  // [1:0] func

   // Response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [spq_pkg::RDATA_W-1:0]  rsp_tdata,  // [31:0] value_out, [36:32] count,
                                                    // [37] is_empty, [39:38] zero
   output logic [1:0]                   rsp_tuser,  // [1:0] status

   // Order register write: 0 smallest first, 1 largest first
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_wdata
);

   spq_pkg::spq_cmd_type               cmd;
   logic [spq_pkg::VALUE_W-1:0]        rsp_value;
   spq_pkg::spq_status_type            rsp_status;
   logic [spq_pkg::COUNT_W-1:0]        rsp_count;
   logic                               rsp_empty;

   // Register writes must only happen with the queue idle; the block itself does not enforce it. The port never stalls.
   assign csr_ready = 1'b1;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_func   (req_tuser),
      .req_value  (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_order  (csr_wdata),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .rsp_empty  (rsp_empty)
   );

   // Response beat packing, lowest bits first.
   assign rsp_tdata = {2'b00, rsp_empty, rsp_count, rsp_value};
   assign rsp_tuser = rsp_status;

endmodule
